### design/iwb_pkg.sv
`default_nettype none

package iwb_pkg;

  localparam int ValW = 11;
  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 32;

  localparam logic OpLocal  = 1'b0;
  localparam logic OpRemote = 1'b1;

  typedef enum logic [CfgAddrW-1:0] {
    RegBoostFloor  = 2'd0,
    RegCpuCapacity = 2'd1,
    RegTickNs      = 2'd2,
    RegStaleNs     = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic            opcode;
    logic [63:0]     time_ns;
    logic            iowait_wake;
    logic            evaluate;
    logic [ValW-1:0] util_in;
  } in_item_t;

  typedef struct packed {
    logic [ValW-1:0] util_out;
    logic            counted;
    logic [ValW-1:0] boost_level;
  } out_item_t;

  typedef struct packed {
    logic [ValW-1:0] boost_floor;
    logic [ValW-1:0] cpu_capacity;
    logic [31:0]     tick_ns;
    logic [31:0]     stale_limit;
  } cfg_t;

  typedef struct packed {
    logic [ValW-1:0] boost;
    logic            pending;
    logic [63:0]     last_time;
  } boost_state_t;

  typedef struct packed {
    logic [ValW-1:0] util;
    logic            counted;
    logic [ValW-1:0] boost;
    logic            scale;
  } step_res_t;

endpackage

`default_nettype wire

### design/iwb_update.sv
`default_nettype none

module iwb_update #(
  parameter int CAP_SCALE = 1024
) (
  input  iwb_pkg::in_item_t     item_i,
  input  iwb_pkg::cfg_t         cfg_i,
  input  iwb_pkg::boost_state_t state_i,
  output iwb_pkg::boost_state_t state_o,
  output iwb_pkg::step_res_t    res_o
);
  import iwb_pkg::*;

  localparam logic [ValW:0] DblLimit =
      (CAP_SCALE > 2047) ? (ValW+1)'(2047) : (ValW+1)'(CAP_SCALE);

  logic [63:0]   elapsed;
  logic          beyond_tick;
  logic          beyond_stale;
  logic [ValW:0] doubled;
  logic [ValW:0] doubled_sat;

  assign elapsed      = item_i.time_ns - state_i.last_time;
  assign beyond_tick  = !elapsed[63] && (elapsed > {32'd0, cfg_i.tick_ns});
  assign beyond_stale = !elapsed[63] && (elapsed > {32'd0, cfg_i.stale_limit});
  assign doubled      = {state_i.boost, 1'b0};
  assign doubled_sat  = (doubled > DblLimit) ? DblLimit : doubled;

  always_comb begin
    logic            do_apply;
    logic [ValW-1:0] bv;
    logic            bp;
    do_apply = 1'b0;
    bv       = state_i.boost;
    bp       = state_i.pending;
    state_o  = state_i;
    res_o.counted = 1'b1;
    res_o.scale   = 1'b0;

    if (item_i.opcode == OpLocal) begin
      if (bv != '0 && beyond_tick) begin
        bv = item_i.iowait_wake ? cfg_i.boost_floor : '0;
        bp = item_i.iowait_wake;
      end else if (item_i.iowait_wake && !bp) begin
        bp = 1'b1;
        bv = (bv != '0) ? doubled_sat[ValW-1:0] : cfg_i.boost_floor;
      end
      state_o.last_time = item_i.time_ns;
      do_apply = item_i.evaluate;
    end else if (beyond_stale) begin
      if (beyond_tick) begin
        bv = '0;
        bp = 1'b0;
      end
      res_o.counted = 1'b0;
    end else if (bv != '0 && beyond_tick) begin
      bv = '0;
      bp = 1'b0;
    end else begin
      do_apply = 1'b1;
    end

    if (do_apply && bv != '0) begin
      if (!bp) begin
        bv = bv >> 1;
        if (bv < cfg_i.boost_floor) begin
          bv = '0;
        end else begin
          res_o.scale = 1'b1;
        end
      end else begin
        bp = 1'b0;
        res_o.scale = 1'b1;
      end
    end

    state_o.boost   = bv;
    state_o.pending = bp;
    res_o.boost     = bv;
    res_o.util      = item_i.util_in;
  end

endmodule

`default_nettype wire

### design/io_wait_boost_tracker.sv
`default_nettype none

// I/O-wait boost tracker for one CPU. It takes one event per cycle while the
// output is not stalled, and passes each event through an input register, a
// stage in which the boost state is updated and the boost is multiplied by
// the CPU capacity, and an output register after the division by CAP_SCALE.
// The first stage reads and writes the state register directly, so events may
// follow each other in consecutive cycles. Configuration registers must only
// be written while the pipeline is empty.
module io_wait_boost_tracker #(
  parameter int CAP_SCALE = 1024
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  iwb_pkg::in_item_t                   in_data_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output iwb_pkg::out_item_t                  out_data_o,
  input  wire                                 cfg_we_i,
  input  wire [iwb_pkg::CfgAddrW-1:0]         cfg_idx_i,
  input  wire [iwb_pkg::CfgDataW-1:0]         cfg_wdata_i
);
  import iwb_pkg::*;

  localparam int ProdW = 2 * ValW;
  localparam int RecK  = ProdW + $clog2(CAP_SCALE);
  localparam int RecW  = ProdW + 2;
  localparam longint unsigned RecM =
      ((64'd1 << RecK) + 64'(CAP_SCALE) - 64'd1) / 64'(CAP_SCALE);
  localparam logic [RecW-1:0] RecMul = RecW'(RecM);

  cfg_t         cfg_q;
  boost_state_t state_q;
  boost_state_t state_d;

  logic         s1_valid_q;
  in_item_t     s1_item_q;
  logic         s2_valid_q;
  step_res_t    s2_res_q;
  logic [ProdW-1:0] s2_prod_q;

  step_res_t    step_res;
  logic         s1_fire;
  logic         s2_fire;
  logic         in_fire;

  logic [ProdW+RecW-1:0] quot_full;
  logic [ProdW-1:0]      quot;
  logic [ValW-1:0]       scaled;
  logic [ValW-1:0]       util_boosted;

  iwb_update #(
    .CAP_SCALE(CAP_SCALE)
  ) u_update (
    .item_i (s1_item_q),
    .cfg_i  (cfg_q),
    .state_i(state_q),
    .state_o(state_d),
    .res_o  (step_res)
  );

  assign s2_fire    = s2_valid_q && (!out_valid_o || !out_stall_i);
  assign s1_fire    = s1_valid_q && (!s2_valid_q || s2_fire);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign quot_full    = (ProdW+RecW)'(s2_prod_q) * (ProdW+RecW)'(RecMul);
  assign quot         = ProdW'(quot_full >> RecK);
  assign scaled       = (quot > ProdW'(2047)) ? ValW'(2047) : quot[ValW-1:0];
  assign util_boosted = (s2_res_q.scale && s2_res_q.util < scaled) ? scaled
                                                                    : s2_res_q.util;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.boost_floor  <= ValW'(128);
      cfg_q.cpu_capacity <= ValW'(1024);
      cfg_q.tick_ns      <= 32'd4000000;
      cfg_q.stale_limit  <= 32'd22500000;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegBoostFloor:  cfg_q.boost_floor  <= cfg_wdata_i[ValW-1:0];
        RegCpuCapacity: cfg_q.cpu_capacity <= cfg_wdata_i[ValW-1:0];
        RegTickNs:      cfg_q.tick_ns      <= cfg_wdata_i;
        RegStaleNs:     cfg_q.stale_limit  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (s1_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        s2_valid_q <= 1'b1;
      end else if (s2_fire) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_fire) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_data_i;
    end
    if (s1_fire) begin
      s2_res_q  <= step_res;
      s2_prod_q <= ProdW'(step_res.boost) * ProdW'(cfg_q.cpu_capacity);
    end
    if (s2_fire) begin
      out_data_o.util_out    <= util_boosted;
      out_data_o.counted     <= s2_res_q.counted;
      out_data_o.boost_level <= s2_res_q.boost;
    end
  end

endmodule

`default_nettype wire

### verif/tb.sv
module tb;
  import iwb_pkg::*;

  localparam int CapScale = 1024;
  localparam int MaxVal = (1 << ValW) - 1;
  localparam int Latency = 3;
  localparam int IdleLimit = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CfgAddrW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  io_wait_boost_tracker #(.CAP_SCALE(CapScale)) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  logic [ValW-1:0] floor_r = 11'd128;
  logic [ValW-1:0] cap_r = 11'd1024;
  logic [31:0] tick_r = 32'd4000000;
  logic [31:0] stale_r = 32'd22500000;
  logic [ValW-1:0] boost_q = '0;
  logic pending_q = 1'b0;
  logic [63:0] last_time = '0;

  in_item_t item_feed[$];
  out_item_t due_results[$];
  out_item_t want;
  logic [63:0] stim_now = '0;
  int gap_left = 0;
  int stall_left = 0;
  int stall_draw = 0;
  int quiet_cycles = 0;
  bit quiet_in = 1'b0;
  bit quiet_out = 1'b0;
  int errors = 0;
  int n_local = 0;
  int n_remote = 0;
  int n_stale = 0;
  int n_results = 0;
  int n_settings = 1;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic bit aged_past(logic [63:0] now, logic [63:0] limit);
    logic [63:0] d;
    d = now - last_time;
    return !d[63] && (d > limit);
  endfunction

  function automatic bit tick_reset(logic [63:0] now, logic wake);
    if (!aged_past(now, {32'd0, tick_r})) return 1'b0;
    boost_q = wake ? floor_r : '0;
    pending_q = wake;
    return 1'b1;
  endfunction

  function automatic void wake_update(logic [63:0] now, logic wake);
    logic [11:0] dbl;
    if (boost_q != '0) begin
      if (tick_reset(now, wake)) return;
    end
    if (!wake || pending_q) return;
    pending_q = 1'b1;
    if (boost_q != '0) begin
      dbl = {boost_q, 1'b0};
      if (dbl > CapScale) dbl = 12'(CapScale);
      if (dbl > MaxVal) dbl = 12'(MaxVal);
      boost_q = dbl[ValW-1:0];
    end else begin
      boost_q = floor_r;
    end
  endfunction

  function automatic logic [ValW-1:0] boosted_util(logic [63:0] now, logic [ValW-1:0] u);
    logic [21:0] prod;
    logic [21:0] b;
    if (boost_q == '0) return u;
    if (tick_reset(now, 1'b0)) return u;
    if (!pending_q) begin
      boost_q = boost_q >> 1;
      if (boost_q < floor_r) begin
        boost_q = '0;
        return u;
      end
    end
    pending_q = 1'b0;
    prod = 22'(boost_q) * 22'(cap_r);
    b = 22'(prod / CapScale);
    if (b > MaxVal) b = 22'(MaxVal);
    return (u < b) ? b[ValW-1:0] : u;
  endfunction

  function automatic out_item_t boost_step(in_item_t it);
    out_item_t r;
    logic [ValW-1:0] u;
    u = it.util_in;
    r.counted = 1'b1;
    if (it.opcode == OpLocal) begin
      wake_update(it.time_ns, it.iowait_wake);
      last_time = it.time_ns;
      if (it.evaluate) u = boosted_util(it.time_ns, u);
    end else if (aged_past(it.time_ns, {32'd0, stale_r})) begin
      void'(tick_reset(it.time_ns, 1'b0));
      r.counted = 1'b0;
    end else begin
      u = boosted_util(it.time_ns, u);
    end
    r.util_out = u;
    r.boost_level = boost_q;
    return r;
  endfunction

  task automatic flag_error(string what);
    errors++;
    if (errors <= 10) $display("%s", what);
  endtask

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        due_results.push_back(boost_step(in_data));
        if (in_data.opcode == OpLocal) n_local++;
        else n_remote++;
        if (!due_results[$].counted) n_stale++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (item_feed.size() != 0) begin
          in_data <= item_feed.pop_front();
          in_valid <= 1'b1;
          if ($urandom_range(0, 39) == 0) quiet_in <= !quiet_in;
          gap_left <= quiet_in ? 0 : int'($urandom_range(0, 8));
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        flag_error($sformatf("unexpected result: util %0d counted %0b boost %0d",
                             out_data.util_out, out_data.counted, out_data.boost_level));
      end else begin
        want = due_results.pop_front();
        if (out_data.util_out !== want.util_out || out_data.counted !== want.counted ||
            out_data.boost_level !== want.boost_level)
          flag_error($sformatf(
              "result %0d: expected util %0d counted %0b boost %0d, got util %0d counted %0b boost %0d",
              n_results, want.util_out, want.counted, want.boost_level,
              out_data.util_out, out_data.counted, out_data.boost_level));
      end
      n_results++;
      if ($urandom_range(0, 39) == 0) quiet_out <= !quiet_out;
      stall_draw = quiet_out ? 0 : int'($urandom_range(0, 8));
      stall_left <= stall_draw;
      out_stall <= (stall_draw != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IdleLimit) begin
      $display("FAIL io_wait_boost_tracker");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_item(logic op, logic [63:0] t, logic wake, logic eval,
                          logic [ValW-1:0] util);
    in_item_t it;
    it.opcode = op;
    it.time_ns = t;
    it.iowait_wake = wake;
    it.evaluate = eval;
    it.util_in = util;
    item_feed.push_back(it);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      RegBoostFloor:  floor_r = val[ValW-1:0];
      RegCpuCapacity: cap_r = val[ValW-1:0];
      RegTickNs:      tick_r = val;
      RegStaleNs:     stale_r = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // The sender holds back until every pending transfer has come out.
  task automatic drain();
    while (item_feed.size() != 0 || in_valid || due_results.size() != 0) @(posedge clk);
    repeat (Latency + 2) @(posedge clk);
  endtask

  function automatic logic [63:0] next_time();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 60) stim_now = stim_now + 64'($urandom_range(0, tick_r));
    else if (k < 72)
      stim_now = stim_now + 64'(tick_r) + 64'd1 + 64'($urandom_range(0, tick_r));
    else if (k < 80)
      stim_now = stim_now + 64'(stale_r) + 64'd1 + 64'($urandom_range(0, 1000));
    else if (k < 88)
      stim_now = last_time + 64'(k[0] ? tick_r : stale_r) + 64'($urandom_range(0, 1));
    else if (k < 94) stim_now = stim_now - 64'($urandom_range(0, 1 << 20));
    else stim_now = stim_now + {$urandom, $urandom};
    return stim_now;
  endfunction

  task automatic random_items(int count);
    int unsigned k;
    logic [ValW-1:0] u;
    repeat (count) begin
      k = $urandom_range(0, 99);
      u = ($urandom_range(0, 6) == 0) ? ValW'($urandom_range(0, MaxVal)) :
                                        ValW'($urandom_range(0, CapScale));
      if (k < 50) add_item(OpLocal, next_time(), 1'b1, 1'b1, u);
      else if (k < 70)
        add_item(OpLocal, next_time(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), u);
      else if (k < 92)
        add_item(OpRemote, next_time(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), u);
      else
        add_item(1'($urandom_range(0, 1)), {$urandom, $urandom}, 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), ValW'($urandom_range(0, MaxVal)));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    add_item(OpLocal, 64'd1000, 1'b1, 1'b0, 11'd0);
    add_item(OpLocal, 64'd2000, 1'b1, 1'b0, 11'd0);
    add_item(OpLocal, 64'd3000, 1'b0, 1'b1, 11'd10);
    add_item(OpLocal, 64'd4000, 1'b1, 1'b1, 11'd1024);
    add_item(OpLocal, 64'd5000, 1'b1, 1'b1, 11'd0);
    add_item(OpLocal, 64'd6000, 1'b1, 1'b1, 11'd0);
    add_item(OpLocal, 64'd7000, 1'b1, 1'b1, 11'd0);
    add_item(OpRemote, 64'd8000, 1'b0, 1'b0, 11'd100);
    add_item(OpRemote, 64'd9000, 1'b1, 1'b1, 11'd0);
    add_item(OpLocal, 64'd4011001, 1'b1, 1'b0, 11'd0);
    add_item(OpLocal, 64'd8011001, 1'b0, 1'b1, 11'd2047);
    add_item(OpRemote, 64'd30511002, 1'b0, 1'b0, 11'd5);
    add_item(OpLocal, 64'd30511003, 1'b1, 1'b1, 11'd0);
    add_item(OpLocal, 64'd30510003, 1'b0, 1'b1, 11'd0);
    add_item(OpLocal, 64'hFFFF_FFFF_FFFF_FF00, 1'b1, 1'b0, 11'd0);
    add_item(OpLocal, 64'h0000_0000_0000_0100, 1'b1, 1'b1, 11'd3);
    add_item(OpRemote, 64'h0000_0000_0000_0200, 1'b1, 1'b1, 11'd0);
    add_item(OpRemote, 64'h8000_0000_0000_0300, 1'b1, 1'b1, 11'd1024);
    add_item(OpLocal, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 11'd0);
    add_item(OpRemote, 64'h7FFF_FFFF_FFFF_FFFF + 64'd22500000, 1'b0, 1'b0, 11'd7);
    add_item(OpRemote, 64'h7FFF_FFFF_FFFF_FFFF + 64'd22500001, 1'b0, 1'b0, 11'd9);
    stim_now = 64'h7FFF_FFFF_FFFF_FFFF;
    random_items(200);
    drain();

    for (int ph = 1; ph < 8; ph++) begin
      case (ph)
        1: begin
          write_reg(RegBoostFloor, 32'd0);
          write_reg(RegCpuCapacity, 32'd1024);
          write_reg(RegTickNs, 32'd50000);
          write_reg(RegStaleNs, 32'd300000);
        end
        2: begin
          write_reg(RegBoostFloor, 32'd1024);
          write_reg(RegCpuCapacity, 32'd0);
          write_reg(RegTickNs, 32'd1);
          write_reg(RegStaleNs, 32'd0);
        end
        3: begin
          write_reg(RegBoostFloor, 32'd2047);
          write_reg(RegCpuCapacity, 32'd2047);
          write_reg(RegTickNs, 32'hFFFF_FFFF);
          write_reg(RegStaleNs, 32'hFFFF_FFFF);
          stim_now = {$urandom, $urandom};
        end
        4: begin
          write_reg(RegBoostFloor, 32'd1);
          write_reg(RegCpuCapacity, 32'd1);
          write_reg(RegTickNs, 32'd0);
          write_reg(RegStaleNs, 32'd3000);
        end
        default: begin
          write_reg(RegBoostFloor, ($urandom_range(0, 4) == 0) ?
                    $urandom_range(0, MaxVal) : $urandom_range(0, CapScale));
          write_reg(RegCpuCapacity, $urandom_range(0, MaxVal));
          write_reg(RegTickNs, (ph == 7) ? $urandom_range(1, 32'hFFFF_FFFF) :
                    $urandom_range(1, 1 << 20));
          write_reg(RegStaleNs, (ph == 7) ? $urandom : $urandom_range(0, 1 << 22));
          if (ph == 5) stim_now = 64'hFFFF_FFFF_FFF0_0000;
        end
      endcase
      n_settings++;
      random_items(235);
      drain();
    end

    if (due_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", due_results.size()));
    $display("Covered %0d events (%0d local, %0d remote, %0d stale) over %0d register settings.",
             n_local + n_remote, n_local, n_remote, n_stale, n_settings);
    $display("Checked %0d results with %0d errors.", n_results, errors);
    if (errors == 0) begin
      $display("PASS io_wait_boost_tracker");
    end else begin
      $display("FAIL io_wait_boost_tracker");
    end
    $finish;
  end

endmodule
